### src/pfal_pkg.sv
// Shared types, constants and helpers for the pool free/active list manager.
package pfal_pkg;

	localparam int NODES  = 64;
	localparam int IDX_W  = $clog2(NODES);
	localparam int CNT_W  = $clog2(NODES + 1);
	localparam int LINK_W = $clog2(NODES + 1);

	// link value that marks "no node"
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODES);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [IDX_W-1:0] node_index;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  granted_node;
		logic              ok;
		logic [CNT_W-1:0]  free_count;
		logic [CNT_W-1:0]  active_count;
		logic [LINK_W-1:0] active_first;
		logic [LINK_W-1:0] active_last;
	} rsp_t;

	// free queue control
	typedef struct packed {
		logic             pop;
		logic             push;
		logic [IDX_W-1:0] node;
	} fifo_ctl_t;

	// active list link writes, one per array per item
	typedef struct packed {
		logic              next_we;
		logic [IDX_W-1:0]  next_addr;
		logic [LINK_W-1:0] next_data;
		logic              prev_we;
		logic [IDX_W-1:0]  prev_addr;
		logic [LINK_W-1:0] prev_data;
	} link_wr_t;

	// queue position increment with wrap at the pool size
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
		if (p == IDX_W'(NODES - 1)) begin
			return '0;
		end
		return p + IDX_W'(1);
	endfunction

endpackage

### src/pfal_free_fifo.sv
// Free list kept as a circular queue with a prefetched head entry.
module pfal_free_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfal_pkg::fifo_ctl_t         ctl,
	output logic [pfal_pkg::IDX_W-1:0]  head
);

	logic [pfal_pkg::IDX_W-1:0] fmem [pfal_pkg::NODES];
	logic [pfal_pkg::NODES-1:0] written_q;
	logic [pfal_pkg::IDX_W-1:0] rd_q;
	logic [pfal_pkg::IDX_W-1:0] wr_q;
	logic [pfal_pkg::IDX_W-1:0] rd_next;
	logic [pfal_pkg::IDX_W-1:0] frd_q;
	logic [pfal_pkg::IDX_W-1:0] byp_data_q;
	logic                       byp_q;
	logic                       dflt_q;

	assign rd_next = ctl.pop ? pfal_pkg::idx_inc(rd_q) : rd_q;

	// slot i holds node i until first written
	assign head = byp_q ? byp_data_q : (dflt_q ? rd_q : frd_q);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			fmem[wr_q] <= ctl.node;
		end
		frd_q <= fmem[rd_next];
	end

	always_ff @(posedge clk) begin
		byp_data_q <= ctl.node;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= '0;
			wr_q      <= '0;
			written_q <= '0;
			byp_q     <= 1'b0;
			dflt_q    <= 1'b1;
		end else begin
			rd_q   <= rd_next;
			byp_q  <= ctl.push && (wr_q == rd_next);
			dflt_q <= !written_q[rd_next];
			if (ctl.push) begin
				wr_q            <= pfal_pkg::idx_inc(wr_q);
				written_q[wr_q] <= 1'b1;
			end
		end
	end

endmodule

### src/pfal_link_store.sv
// Next/prev link memories of the active list, one write and one read port each.
module pfal_link_store (
	input  logic                        clk,
	input  pfal_pkg::link_wr_t          wr,
	input  logic                        rd_en,
	input  logic [pfal_pkg::IDX_W-1:0]  rd_addr,
	output logic [pfal_pkg::LINK_W-1:0] next_rd,
	output logic [pfal_pkg::LINK_W-1:0] prev_rd
);

	logic [pfal_pkg::LINK_W-1:0] nmem [pfal_pkg::NODES];
	logic [pfal_pkg::LINK_W-1:0] pmem [pfal_pkg::NODES];
	logic [pfal_pkg::LINK_W-1:0] nrd_q;
	logic [pfal_pkg::LINK_W-1:0] prd_q;

	assign next_rd = nrd_q;
	assign prev_rd = prd_q;

	// read data forwards a write to the same entry in the same cycle
	always_ff @(posedge clk) begin
		if (wr.next_we) begin
			nmem[wr.next_addr] <= wr.next_data;
		end
		if (rd_en) begin
			if (wr.next_we && (wr.next_addr == rd_addr)) begin
				nrd_q <= wr.next_data;
			end else begin
				nrd_q <= nmem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.prev_we) begin
			pmem[wr.prev_addr] <= wr.prev_data;
		end
		if (rd_en) begin
			if (wr.prev_we && (wr.prev_addr == rd_addr)) begin
				prd_q <= wr.prev_data;
			end else begin
				prd_q <= pmem[rd_addr];
			end
		end
	end

endmodule

### src/pool_free_active_list_manager.sv
// Pool free/active list manager: allocate and release nodes of a fixed pool.
//
// Request channel (req_valid / req_stall / req): cmd selects allocate or
// release of req.node_index. Allocate hands out the oldest free node and
// appends it to the active list; release unlinks an active node and queues
// it as the newest free node. Releasing a node that is not active is ignored.
// Response channel (rsp_valid / rsp_stall / rsp): one item per request with
// the granted node, ok, both list counts and the active head and tail.
// Throughput: one item per cycle while rsp is not stalled; the next request's
// link read overlaps the current item's link update in the two link memories.
// When rsp is stalled the response register holds and the item behind it
// waits in the request register; req_stall rises only while both are full.
// Reset: all free nodes queued 0 to NODES-1, active list empty, no items
// in flight. No clearing pass is needed; free queue slots start out as
// their own index.
module pool_free_active_list_manager (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pfal_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pfal_pkg::rsp_t  rsp
);

	logic                        valid_s1_q;
	logic                        cmd_s1;
	logic [pfal_pkg::IDX_W-1:0]  idx_s1;
	logic                        rsp_valid_q;
	pfal_pkg::rsp_t              rsp_q;
	logic [pfal_pkg::NODES-1:0]  in_use_q;
	logic [pfal_pkg::LINK_W-1:0] busy_first_q;
	logic [pfal_pkg::LINK_W-1:0] busy_last_q;
	logic [pfal_pkg::CNT_W-1:0]  free_total_q;
	logic [pfal_pkg::CNT_W-1:0]  busy_total_q;

	logic                        s1_go;
	logic                        req_fire;
	logic [pfal_pkg::IDX_W-1:0]  free_head;
	logic [pfal_pkg::LINK_W-1:0] next_rd;
	logic [pfal_pkg::LINK_W-1:0] prev_rd;
	logic [pfal_pkg::LINK_W-1:0] idx_ext;
	logic [pfal_pkg::LINK_W-1:0] head_ext;
	logic [pfal_pkg::LINK_W-1:0] nx;
	logic [pfal_pkg::LINK_W-1:0] pv;

	pfal_pkg::fifo_ctl_t         fifo_ctl;
	pfal_pkg::link_wr_t          link_wr;
	logic                        ok;
	logic [pfal_pkg::IDX_W-1:0]  granted;
	logic [pfal_pkg::IDX_W-1:0]  use_addr;
	logic [pfal_pkg::LINK_W-1:0] busy_first_d;
	logic [pfal_pkg::LINK_W-1:0] busy_last_d;
	logic [pfal_pkg::CNT_W-1:0]  free_total_d;
	logic [pfal_pkg::CNT_W-1:0]  busy_total_d;

	assign s1_go     = valid_s1_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1_q && rsp_valid_q && rsp_stall;
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign idx_ext  = pfal_pkg::LINK_W'(idx_s1);
	assign head_ext = pfal_pkg::LINK_W'(free_head);
	// tail's next and head's prev are implied, never read from memory
	assign nx = (idx_ext == busy_last_q)  ? pfal_pkg::LINK_NONE : next_rd;
	assign pv = (idx_ext == busy_first_q) ? pfal_pkg::LINK_NONE : prev_rd;

	pfal_free_fifo u_free (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.head   (free_head)
	);

	pfal_link_store u_links (
		.clk     (clk),
		.wr      (link_wr),
		.rd_en   (req_fire),
		.rd_addr (req.node_index),
		.next_rd (next_rd),
		.prev_rd (prev_rd)
	);

	always_comb begin
		fifo_ctl     = '0;
		link_wr      = '0;
		ok           = 1'b0;
		granted      = '0;
		use_addr     = idx_s1;
		busy_first_d = busy_first_q;
		busy_last_d  = busy_last_q;
		free_total_d = free_total_q;
		busy_total_d = busy_total_q;
		case (cmd_s1)
			pfal_pkg::CMD_ALLOC: begin
				if (free_total_q != '0) begin
					ok                = 1'b1;
					granted           = free_head;
					use_addr          = free_head;
					fifo_ctl.pop      = 1'b1;
					link_wr.prev_we   = 1'b1;
					link_wr.prev_addr = free_head;
					link_wr.prev_data = busy_last_q;
					if (busy_last_q != pfal_pkg::LINK_NONE) begin
						link_wr.next_we   = 1'b1;
						link_wr.next_addr = busy_last_q[pfal_pkg::IDX_W-1:0];
						link_wr.next_data = head_ext;
					end else begin
						busy_first_d = head_ext;
					end
					busy_last_d  = head_ext;
					free_total_d = free_total_q - pfal_pkg::CNT_W'(1);
					busy_total_d = busy_total_q + pfal_pkg::CNT_W'(1);
				end
			end
			pfal_pkg::CMD_FREE: begin
				if ((idx_ext < pfal_pkg::LINK_NONE) && in_use_q[idx_s1]) begin
					ok                = 1'b1;
					fifo_ctl.push     = 1'b1;
					fifo_ctl.node     = idx_s1;
					link_wr.prev_we   = (nx != pfal_pkg::LINK_NONE);
					link_wr.prev_addr = nx[pfal_pkg::IDX_W-1:0];
					link_wr.prev_data = pv;
					link_wr.next_we   = (pv != pfal_pkg::LINK_NONE);
					link_wr.next_addr = pv[pfal_pkg::IDX_W-1:0];
					link_wr.next_data = nx;
					if (busy_first_q == idx_ext) begin
						busy_first_d = nx;
					end
					if (busy_last_q == idx_ext) begin
						busy_last_d = pv;
					end
					free_total_d = free_total_q + pfal_pkg::CNT_W'(1);
					busy_total_d = busy_total_q - pfal_pkg::CNT_W'(1);
				end
			end
			default: ;
		endcase
		if (!s1_go) begin
			fifo_ctl.pop    = 1'b0;
			fifo_ctl.push   = 1'b0;
			link_wr.next_we = 1'b0;
			link_wr.prev_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1 <= req.cmd;
			idx_s1 <= req.node_index;
		end
		if (s1_go) begin
			rsp_q.granted_node <= granted;
			rsp_q.ok           <= ok;
			rsp_q.free_count   <= free_total_d;
			rsp_q.active_count <= busy_total_d;
			rsp_q.active_first <= busy_first_d;
			rsp_q.active_last  <= busy_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
			in_use_q     <= '0;
			busy_first_q <= pfal_pkg::LINK_NONE;
			busy_last_q  <= pfal_pkg::LINK_NONE;
			free_total_q <= pfal_pkg::CNT_W'(pfal_pkg::NODES);
			busy_total_q <= '0;
		end else begin
			if (req_fire) begin
				valid_s1_q <= 1'b1;
			end else if (s1_go) begin
				valid_s1_q <= 1'b0;
			end
			if (s1_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (s1_go) begin
				if (ok) begin
					in_use_q[use_addr] <= (cmd_s1 == pfal_pkg::CMD_ALLOC);
				end
				busy_first_q <= busy_first_d;
				busy_last_q  <= busy_last_d;
				free_total_q <= free_total_d;
				busy_total_q <= busy_total_d;
			end
		end
	end

endmodule

### src/pfal_checker.sv
// Port-level checks for the pool free/active list manager, bound to the top level.
module pfal_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input pfal_pkg::rsp_t rsp
);

	// every node sits on exactly one list
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((pfal_pkg::CNT_W + 1)'(rsp.free_count)
			+ (pfal_pkg::CNT_W + 1)'(rsp.active_count)) == pfal_pkg::NODES)
		else $error("list counts do not add up to pool size");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.active_count == '0) ==
			(rsp.active_first == pfal_pkg::LINK_NONE)))
		else $error("active head disagrees with active count");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.active_count == pfal_pkg::CNT_W'(1))) |->
			(rsp.active_first == rsp.active_last))
		else $error("single active node with distinct head and tail");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.ok) |-> (rsp.granted_node == '0))
		else $error("failed item reports a granted node");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind pool_free_active_list_manager pfal_checker u_pfal_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
